>>> rtl/core/rbht_pkg.sv
// Package for the ray versus box-table hit test: constants, item types and
// the fixed-point widths shared by controller and datapath. No dependencies.
`default_nettype none
package rbht_pkg;

    localparam int Entries  = 16;
    localparam int SlotW    = 4;
    localparam int CoordW   = 20;   // signed coordinate, enough for pos + size*16 + ray
    localparam int ProdW    = 44;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // Edge index order: left, top, right, bottom.
    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_TOP    = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [3:0]         slot;
        logic [14:0]        pos_x;
        logic [14:0]        pos_y;
        logic [7:0]         box_width;
        logic [7:0]         box_height;
        logic               alive;
        logic signed [15:0] ray_dx;
        logic signed [15:0] ray_dy;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] hit_slot;
    } out_item_t;

    typedef struct packed {
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [7:0]  box_width;
        logic [7:0]  box_height;
        logic        alive;
    } box_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic             load;      // capture the input item
        logic             do_write;  // store the captured entry
        logic             set_org;   // form the ray from the caster entry
        logic             rd_box;    // read the entry at box_idx
        logic [SlotW-1:0] box_idx;
        logic             seg_go;    // start a segment test
        logic [1:0]       edge_sel;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic kind;
        logic [SlotW-1:0] slot;
        logic box_alive;
        logic seg_done;
        logic seg_hit;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/ray_box_table_hit_test.sv
// Channel | handshake           | payload
// input   | start & !busy       | item (rbht_pkg::in_item_t)
// result  | done, one cycle     | result (rbht_pkg::out_item_t)
// A write shows its result once its decode state has registered it. A cast
// walks the slots in order and stops at the first hit: a skipped slot passes
// the read, check and next states, and a live box gets up to four segment tests
// (one per edge) on the shared segment unit, each waited for in turn.
// Reset clears control state and the table valid bits; no clearing pass.
// The result cannot be stalled: it is shown for one cycle with done high.
`default_nettype none
module ray_box_table_hit_test (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rbht_pkg::in_item_t   item,
    output logic                      done,
    output rbht_pkg::out_item_t       result
);
    import rbht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rbht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd), .done(done), .result(result)
    );

    rbht_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cmd(cmd), .stat(stat)
    );
endmodule
`default_nettype wire

>>> rtl/core/rbht_seg.sv
// Sequential exact segment crossing test with step-shared multipliers.
// Depends on rbht_pkg.
`default_nettype none
module rbht_seg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              go,
    input  wire logic signed [rbht_pkg::CoordW-1:0] x1,
    input  wire logic signed [rbht_pkg::CoordW-1:0] y1,
    input  wire logic signed [rbht_pkg::CoordW-1:0] x2,
    input  wire logic signed [rbht_pkg::CoordW-1:0] y2,
    input  wire logic signed [rbht_pkg::CoordW-1:0] x3,
    input  wire logic signed [rbht_pkg::CoordW-1:0] y3,
    input  wire logic signed [rbht_pkg::CoordW-1:0] x4,
    input  wire logic signed [rbht_pkg::CoordW-1:0] y4,
    output logic                                   done,
    output logic                                   hit
);
    import rbht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_CMP1, S_CMP2
    } seg_state_t;

    typedef enum logic [1:0] { C_GEN, C_VRAY, C_VEDGE } case_t;

    localparam int WideW = 64;
    typedef logic signed [WideW-1:0] wide_t;

    seg_state_t state_reg, state_next;
    case_t      case_reg, case_next;
    logic       done_reg, done_next, hit_reg, hit_next;
    wide_t      acc_reg, acc_next, t_reg, t_next, den_reg, den_next;
    wide_t      lo_reg, lo_next, hi_reg, hi_next;

    // Shared multiplier operands, selected by state.
    logic signed [CoordW+1:0] ma, mb;
    wide_t prod;

    wide_t w1, w2, w3, w4, v1, v2, v3, v4;
    wide_t px, py, qx, qy, xv, ya, yb;
    wide_t a, b, c, e, dd;

    always_comb
    begin
        w1 = WideW'(x1); w2 = WideW'(x2); w3 = WideW'(x3); w4 = WideW'(x4);
        v1 = WideW'(y1); v2 = WideW'(y2); v3 = WideW'(y3); v4 = WideW'(y4);
        a = w2 - w1; b = v2 - v1; c = w4 - w3; e = v4 - v3;
        // y_between operands: vertical ray uses the edge's line at x1.
        if (case_reg == C_VRAY)
        begin
            px = w3; py = v3; qx = w4; qy = v4; xv = w1; ya = v1; yb = v2;
        end
        else
        begin
            px = w1; py = v1; qx = w2; qy = v2; xv = w3; ya = v3; yb = v4;
        end
        dd = qx - px;
    end

    // One multiplier, operands chosen by step.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_M0: if (case_reg == C_GEN)
                  begin ma = (CoordW+2)'(a); mb = (CoordW+2)'(e); end
                  else
                  begin ma = (CoordW+2)'(py); mb = (CoordW+2)'(dd); end
            S_M1: if (case_reg == C_GEN)
                  begin ma = (CoordW+2)'(b); mb = (CoordW+2)'(c); end
                  else
                  begin ma = (CoordW+2)'(qy - py); mb = (CoordW+2)'(xv - px); end
            S_M2: if (case_reg == C_GEN)
                  begin ma = (CoordW+2)'(w3 - w1); mb = (CoordW+2)'(e); end
            S_M3: if (case_reg == C_GEN)
                  begin ma = (CoordW+2)'(v3 - v1); mb = (CoordW+2)'(c); end
            default: ;
        endcase
        prod = WideW'(ma) * WideW'(mb);
    end

    // Wide values times coordinates (t*a, x1*den, lo*den, hi*den) in the tail
    // steps are formed from two partial products split at bit 24.
    logic signed [CoordW+1:0] sm;
    wide_t big, pp_lo, pp_hi;
    always_comb
    begin
        sm  = '0;
        big = '0;
        unique case (state_reg)
            S_M4: begin big = t_reg; sm = (CoordW+2)'(a); end
            S_M5: begin big = den_reg; sm = (CoordW+2)'(w1); end
            S_M6: begin big = den_reg; sm = (CoordW+2)'(lo_reg); end
            S_CMP1: begin big = den_reg; sm = (CoordW+2)'(hi_reg); end
            default: ;
        endcase
        pp_lo = $signed({1'b0, big[23:0]}) * WideW'(sm);
        pp_hi = WideW'($signed(big[WideW-1:24])) * WideW'(sm);
    end
    wide_t bigprod;
    assign bigprod = pp_lo + (pp_hi <<< 24);

    wide_t mn12, mx12, mn34, mx34, olo, ohi;
    always_comb
    begin
        mn12 = (w1 < w2) ? w1 : w2; mx12 = (w1 > w2) ? w1 : w2;
        mn34 = (w3 < w4) ? w3 : w4; mx34 = (w3 > w4) ? w3 : w4;
        olo  = (mn12 > mn34) ? mn12 : mn34;
        ohi  = (mx12 < mx34) ? mx12 : mx34;
    end

    // Step sequencing and the accumulation of products.
    always_comb
    begin
        state_next = state_reg;
        case_next  = case_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        acc_next   = acc_reg;
        t_next     = t_reg;
        den_next   = den_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        unique case (state_reg)
            S_IDLE: if (go) state_next = S_CLASS;
            S_CLASS:
            begin
                lo_next = olo;
                hi_next = ohi;
                if (ohi < olo)
                begin
                    hit_next = 1'b0; done_next = 1'b1; state_next = S_IDLE;
                end
                else if (w1 == w2 && w3 == w4)
                begin
                    hit_next = (w1 == w4); done_next = 1'b1; state_next = S_IDLE;
                end
                else
                begin
                    case_next  = (w1 == w2) ? C_VRAY : ((w3 == w4) ? C_VEDGE : C_GEN);
                    state_next = S_M0;
                end
            end
            S_M0: begin acc_next = prod; state_next = S_M1; end
            S_M1:
            begin
                if (case_reg == C_GEN)
                begin
                    den_next = acc_reg - prod;
                    if (acc_reg - prod == 0)
                    begin
                        hit_next = 1'b0; done_next = 1'b1; state_next = S_IDLE;
                    end
                    else state_next = S_M2;
                end
                else
                begin
                    // n = py*d + (qy-py)*(xv-px); bounds from ya, yb.
                    if (dd < 0)
                    begin
                        acc_next = -(acc_reg + prod); den_next = -dd;
                    end
                    else
                    begin
                        acc_next = acc_reg + prod; den_next = dd;
                    end
                    lo_next = (ya < yb) ? ya : yb;
                    hi_next = (ya > yb) ? ya : yb;
                    state_next = S_M6;
                end
            end
            S_M2: begin t_next = prod; state_next = S_M3; end
            S_M3: begin t_next = t_reg - prod; state_next = S_M4; end
            S_M4: begin acc_next = bigprod; state_next = S_M5; end
            S_M5:
            begin
                if (den_reg < 0)
                begin
                    acc_next = -(acc_reg + bigprod); den_next = -den_reg;
                end
                else acc_next = acc_reg + bigprod;
                state_next = S_M6;
            end
            S_M6: begin t_next = bigprod; state_next = S_CMP1; end
            S_CMP1: begin lo_next = bigprod; state_next = S_CMP2; end
            S_CMP2:
            begin
                // t holds lo*den, lo_reg now hi*den.
                if (case_reg == C_GEN)
                    hit_next = (acc_reg >= t_reg) && (acc_reg <= lo_reg);
                else
                    hit_next = (acc_reg > t_reg) && (acc_reg < lo_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            case_reg  <= C_GEN;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case_reg  <= case_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        t_reg   <= t_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
    end

    assign done = done_reg;
    assign hit  = hit_reg;
endmodule
`default_nettype wire

>>> rtl/core/rbht_datapath.sv
// Datapath: box table, ray origin and end registers, edge selection and the
// segment test unit. Depends on rbht_pkg and rbht_seg.
`default_nettype none
module rbht_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rbht_pkg::in_item_t item,
    input  wire rbht_pkg::cmd_t     cmd,
    output rbht_pkg::stat_t         stat
);
    import rbht_pkg::*;

    typedef logic signed [CoordW-1:0] crd_t;

    in_item_t item_reg;
    box_t     table_mem [Entries];
    logic [Entries-1:0] valid_reg;
    box_t     box_reg;
    logic     box_ok_reg;
    box_t     org_reg;
    crd_t     cx_reg, cy_reg, ex_reg, ey_reg;
    logic     seg_done, seg_hit;

    // Caster centre from the entry read at the transfer.
    crd_t cx, cy;
    always_comb
    begin
        cx = crd_t'(org_reg.pos_x) + crd_t'({org_reg.box_width, 3'b000});
        cy = crd_t'(org_reg.pos_y) + crd_t'({org_reg.box_height, 3'b000});
    end

    // Table and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.do_write)
            valid_reg[item_reg.slot] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            // A never-written entry reads as zero.
            org_reg  <= valid_reg[item.slot] ? table_mem[item.slot] : box_t'('0);
        end
        if (cmd.do_write)
            table_mem[item_reg.slot] <= '{item_reg.pos_x, item_reg.pos_y,
                item_reg.box_width, item_reg.box_height, item_reg.alive};
        if (cmd.set_org)
        begin
            cx_reg <= cx;
            cy_reg <= cy;
            ex_reg <= cx + crd_t'(item_reg.ray_dx);
            ey_reg <= cy + crd_t'(item_reg.ray_dy);
        end
        if (cmd.rd_box)
        begin
            box_reg    <= table_mem[cmd.box_idx];
            box_ok_reg <= valid_reg[cmd.box_idx] && (cmd.box_idx != item_reg.slot);
        end
    end

    // Edge endpoints for the selected side.
    crd_t l, t, r, bm, x3, y3, x4, y4;
    always_comb
    begin
        l  = crd_t'(box_reg.pos_x);
        t  = crd_t'(box_reg.pos_y);
        r  = l + crd_t'({box_reg.box_width, 4'b0000});
        bm = t + crd_t'({box_reg.box_height, 4'b0000});
        unique case (cmd.edge_sel)
            EDGE_LEFT:   begin x3 = l; y3 = bm; x4 = l; y4 = t;  end
            EDGE_TOP:    begin x3 = l; y3 = t;  x4 = r; y4 = t;  end
            EDGE_RIGHT:  begin x3 = r; y3 = t;  x4 = r; y4 = bm; end
            default:     begin x3 = l; y3 = bm; x4 = r; y4 = bm; end
        endcase
    end

    rbht_seg u_seg (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (cmd.seg_go),
        .x1   (cx_reg), .y1(cy_reg), .x2(ex_reg), .y2(ey_reg),
        .x3   (x3), .y3(y3), .x4(x4), .y4(y4),
        .done (seg_done),
        .hit  (seg_hit)
    );

    always_comb
    begin
        stat.kind      = item_reg.kind;
        stat.slot      = item_reg.slot;
        stat.box_alive = box_ok_reg && box_reg.alive;
        stat.seg_done  = seg_done;
        stat.seg_hit   = seg_hit;
    end
endmodule
`default_nettype wire

>>> rtl/core/rbht_ctrl.sv
// Controller: walks the table slot by slot and edge by edge, drives the
// datapath and forms the result. Depends on rbht_pkg.
`default_nettype none
module rbht_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire rbht_pkg::stat_t     stat,
    output rbht_pkg::cmd_t           cmd,
    output logic                     done,
    output rbht_pkg::out_item_t      result
);
    import rbht_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE, C_DECODE, C_ORG, C_READ, C_CHECK, C_WAIT, C_NEXT
    } ctl_state_t;

    ctl_state_t state_reg;
    logic [SlotW-1:0] idx_reg;
    logic [1:0] edge_reg;
    logic done_reg;
    out_item_t result_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = start && (state_reg == C_IDLE);
        cmd.do_write = (state_reg == C_DECODE) && (stat.kind == KIND_WRITE);
        cmd.set_org  = (state_reg == C_ORG);
        cmd.rd_box   = (state_reg == C_READ);
        cmd.box_idx  = idx_reg;
        cmd.seg_go   = (state_reg == C_CHECK) && stat.box_alive;
        cmd.edge_sel = edge_reg;
    end

    // State, walk counters and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            idx_reg    <= '0;
            edge_reg   <= EDGE_LEFT;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: if (start) state_reg <= C_DECODE;
                C_DECODE:
                    if (stat.kind == KIND_WRITE)
                    begin
                        result_reg <= '{1'b0, stat.slot};
                        done_reg   <= 1'b1;
                        state_reg  <= C_IDLE;
                    end
                    else
                        state_reg <= C_ORG;
                C_ORG:
                begin
                    idx_reg   <= '0;
                    edge_reg  <= EDGE_LEFT;
                    state_reg <= C_READ;
                end
                C_READ: state_reg <= C_CHECK;
                C_CHECK: state_reg <= stat.box_alive ? C_WAIT : C_NEXT;
                C_WAIT:
                    if (stat.seg_done)
                    begin
                        if (stat.seg_hit)
                        begin
                            result_reg <= '{1'b1, idx_reg};
                            done_reg   <= 1'b1;
                            state_reg  <= C_IDLE;
                        end
                        else if (edge_reg != EDGE_BOTTOM)
                        begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= C_CHECK;
                        end
                        else
                            state_reg <= C_NEXT;
                    end
                C_NEXT:
                begin
                    edge_reg <= EDGE_LEFT;
                    if (idx_reg == SlotW'(Entries - 1))
                    begin
                        result_reg <= '0;
                        done_reg   <= 1'b1;
                        state_reg  <= C_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= C_READ;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != C_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

>>> rtl/core/rbht_checker.sv
// Port checker for the hit test, bound to the top level.
// Depends on rbht_pkg.
`default_nettype none
module rbht_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire rbht_pkg::out_item_t result
);
    import rbht_pkg::*;

    // An accepted item makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("not busy after accept");

    // A result ends the busy period.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy with result");

    // A result follows a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without work");

    // A result carries known values.
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result)) else $error("unknown result");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe too long");
endmodule

bind ray_box_table_hit_test rbht_checker u_rbht_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
`default_nettype wire
